FILE: hdl/bmorph_pkg.sv
// Shared types, codes and position helper for the 3x3 binary morphology block.
package bmorph_pkg;

    localparam int ROW_W = 10;

    // Operation codes held in the mode register
    localparam logic [1:0] MODE_ERODE  = 2'd0;
    localparam logic [1:0] MODE_DILATE = 2'd1;
    localparam logic [1:0] MODE_OPEN   = 2'd2;
    localparam logic [1:0] MODE_CLOSE  = 2'd3;

    // Register indexes on the configuration channel
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Raster position; rows go negative before the first valid center
    typedef struct packed {
        logic signed [ROW_W-1:0] row;
        logic [7:0]              col;
    } t_pos;

    typedef struct packed {
        logic [7:0] width;
        logic [7:0] height;
    } t_dims;

    typedef struct packed {
        logic dilate;
        logic bypass;
    } t_stage_ctl;

    // Position W+1 steps earlier in raster order
    function automatic t_pos f_prev(input t_pos p, input logic [7:0] w);
        t_pos q;
        if (p.col == 8'd0) begin
            q.row = p.row - 10'sd2;
            q.col = w - 8'd1;
        end else begin
            q.row = p.row - 10'sd1;
            q.col = p.col - 8'd1;
        end
        return q;
    endfunction

endpackage

FILE: hdl/bmorph_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmorph_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/bmorph_stage.sv
// One 3x3 morphology stage: two-row line store, sliding window and frame-edge mask.
module bmorph_stage #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bmorph_pkg::t_stage_ctl i_ctl,
    input  bmorph_pkg::t_dims      i_dims,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_bit,
    input  bmorph_pkg::t_pos       i_pos,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_bit,
    output bmorph_pkg::t_pos       o_pos
);
    import bmorph_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic             r_p_valid;
    logic             r_p_bit;
    t_pos             r_p_pos;
    logic             r_w_valid;
    logic [2:0][2:0]  r_win;
    logic [2:0][2:0]  n_win;
    t_pos             r_c_pos;
    logic             r_by_bit;
    t_pos             r_by_pos;
    logic             r_fwd;
    logic [1:0]       r_fwd_data;

    logic             p_adv;
    logic             load_p;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [1:0]       ram_q;
    logic [1:0]       line_q;
    logic [1:0]       wr_word;
    logic [2:0]       row_ok;
    logic [2:0]       col_ok;
    logic [2:0][2:0]  mask;
    logic             res;

    assign p_adv   = r_p_valid && (!r_w_valid || i_ready);
    assign o_ready = !r_p_valid || p_adv;
    assign load_p  = i_valid && o_ready;

    assign rd_addr = AW'(i_pos.col);
    assign wr_addr = AW'(r_p_pos.col);

    // bit 0: row above the incoming pixel, bit 1: two rows above
    assign line_q  = r_fwd ? r_fwd_data : ram_q;
    assign wr_word = {line_q[0], r_p_bit};

    bmorph_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (p_adv),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_word),
        .i_rd_en   (load_p),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    always_comb begin
        n_win[0]    = r_win[1];
        n_win[1]    = r_win[2];
        n_win[2]    = {r_p_bit, line_q[0], line_q[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_w_valid <= 1'b0;
            r_fwd     <= 1'b0;
            r_win     <= '0;
        end else begin
            if (o_ready) begin
                r_p_valid <= i_valid;
            end
            if (p_adv) begin
                r_w_valid <= 1'b1;
                r_win     <= n_win;
            end else if (i_ready) begin
                r_w_valid <= 1'b0;
            end
            // single-column frames read the word being written in the same cycle
            if (load_p) begin
                r_fwd <= p_adv && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_p) begin
            r_p_bit    <= i_bit;
            r_p_pos    <= i_pos;
            r_fwd_data <= wr_word;
        end
        if (p_adv) begin
            r_c_pos  <= f_prev(r_p_pos, i_dims.width);
            r_by_bit <= r_p_bit;
            r_by_pos <= r_p_pos;
        end
    end

    // drop neighbors that fall outside the frame
    always_comb begin
        row_ok[0] = (r_c_pos.row >= 10'sd1);
        row_ok[1] = 1'b1;
        row_ok[2] = ((r_c_pos.row + 10'sd1) < $signed({2'b00, i_dims.height}));
        col_ok[0] = (r_c_pos.col != 8'd0);
        col_ok[1] = 1'b1;
        col_ok[2] = (({1'b0, r_c_pos.col} + 9'd1) < {1'b0, i_dims.width});
        for (int ci = 0; ci < 3; ci++) begin
            for (int ri = 0; ri < 3; ri++) begin
                mask[ci][ri] = col_ok[ci] & row_ok[ri];
            end
        end
        res = i_ctl.dilate ? (|(r_win & mask)) : (&(r_win | ~mask));
    end

    assign o_valid = r_w_valid;
    assign o_bit   = i_ctl.bypass ? r_by_bit : res;
    assign o_pos   = i_ctl.bypass ? r_by_pos : r_c_pos;

    a_win_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_w_valid && !i_ready) |=> (r_w_valid && $stable(r_win)))
        else $error("window changed while its result was stalled");

endmodule

FILE: hdl/binary_morphology_3x3.sv
// Top level of the 3x3 square binary morphology block (erode, dilate, open, close).
//
// Usage:
//   Slave stream carries one pixel per transfer in raster order: tdata[0] is the
//   pixel, tuser marks a flush transfer. Master stream returns one result per
//   pixel position: tdata holds bit, row and column, tlast marks the frame's
//   last pixel. The configuration channel writes mode, width and height; any
//   write to one of these restarts the frame, so write only while idle.
//   After the W*H pixels, send flush transfers (W+1 for erode/dilate, 2*(W+1)
//   for open/close) to drain the pending results; a flush inside the frame is
//   taken and discarded, a pixel sent while draining counts as a flush.
//   Throughput: one transfer per cycle while the receiver keeps taking results;
//   each of the two cascaded stages does a line store read/write and window shift.
//   Latency: the result for a pixel leaves with the transfer W+1 (or 2*(W+1))
//   positions later, plus five register stages from input to output.
//   Reset: mode erosion, 255x255 frame (width capped at MAX_WIDTH), counters
//   and pipeline cleared. Line stores are not cleared: entries outside the
//   current frame are masked off, so no clearing pass is needed.
//   Receiver stall: the output register holds its result, the pipeline fills
//   behind it and tready drops once every stage is occupied.
module binary_morphology_3x3 #(
    parameter int MAX_WIDTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // pixel stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] pixel_bit, [7:1] zero
    input  logic        i_s_axis_tuser,   // [0] flush
    // result stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [0] result_bit, [8:1] result_row,
                                          // [16:9] result_col, [23:17] zero
    output logic        o_m_axis_tlast    // frame_end
);
    import bmorph_pkg::*;

    localparam logic [7:0] WIDTH_RST = 8'((MAX_WIDTH < 255) ? MAX_WIDTH : 255);

    logic [1:0]   r_mode;
    t_dims        r_dims;
    t_pos         r_in_pos;
    t_pos         n_in_pos;

    logic         r_out_valid;
    logic         r_out_bit;
    logic [7:0]   r_out_row;
    logic [7:0]   r_out_col;
    logic         r_out_last;

    logic         cfg_fire;
    logic         cfg_hit;
    logic [7:0]   cfg_width;
    logic [7:0]   cfg_height;
    logic         s_fire;
    logic         s_count;
    logic         in_frame;
    logic         two_stage;
    t_pos         out1_pos;
    t_pos         out2_pos;
    t_pos         sel_pos;
    logic         frame_done;
    logic signed [ROW_W-1:0] h_last;
    logic [7:0]   w_last;

    t_stage_ctl   s1_ctl;
    t_stage_ctl   s2_ctl;
    logic         s1_valid;
    logic         s1_ready;
    logic         s1_bit;
    t_pos         s1_pos;
    logic         s2_in_ready;
    logic         s2_valid;
    logic         s2_ready;
    logic         s2_bit;
    t_pos         s2_pos;
    logic         emit;
    logic         load_out;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_fire && ((i_cfg_index == REG_MODE) ||
                                      (i_cfg_index == REG_WIDTH) ||
                                      (i_cfg_index == REG_HEIGHT));

    // hold effective sizes: zero acts as one, width capped at the line store
    always_comb begin
        if (i_cfg_data == 8'd0) begin
            cfg_width = 8'd1;
        end else if ({24'd0, i_cfg_data} > 32'(MAX_WIDTH)) begin
            cfg_width = 8'(MAX_WIDTH);
        end else begin
            cfg_width = i_cfg_data;
        end
        cfg_height = (i_cfg_data == 8'd0) ? 8'd1 : i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_ERODE;
            r_dims.width  <= WIDTH_RST;
            r_dims.height <= 8'd255;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                REG_MODE:   r_mode        <= i_cfg_data[1:0];
                REG_WIDTH:  r_dims.width  <= cfg_width;
                REG_HEIGHT: r_dims.height <= cfg_height;
                default:    r_mode        <= r_mode;
            endcase
        end
    end

    assign two_stage = (r_mode == MODE_OPEN) || (r_mode == MODE_CLOSE);
    assign s1_ctl.dilate = (r_mode == MODE_DILATE) || (r_mode == MODE_CLOSE);
    assign s1_ctl.bypass = 1'b0;
    assign s2_ctl.dilate = (r_mode == MODE_OPEN);
    assign s2_ctl.bypass = !two_stage;

    // ------------------------------------------------------- input position
    assign h_last   = $signed({2'b00, r_dims.height}) - 10'sd1;
    assign w_last   = r_dims.width - 8'd1;
    assign in_frame = (r_in_pos.row < $signed({2'b00, r_dims.height}));

    assign s_fire  = i_s_axis_tvalid && o_s_axis_tready;
    // drop a flush that arrives before the frame's pixels are all in
    assign s_count = s_fire && !(i_s_axis_tuser && in_frame);

    // output position this transfer produces; the last one ends the frame
    assign out1_pos   = f_prev(r_in_pos, r_dims.width);
    assign out2_pos   = f_prev(out1_pos, r_dims.width);
    assign sel_pos    = two_stage ? out2_pos : out1_pos;
    assign frame_done = (sel_pos.row == h_last) && (sel_pos.col == w_last);

    always_comb begin
        n_in_pos = r_in_pos;
        if (frame_done) begin
            n_in_pos = '0;
        end else if (({1'b0, r_in_pos.col} + 9'd1) == {1'b0, r_dims.width}) begin
            n_in_pos.col = 8'd0;
            n_in_pos.row = r_in_pos.row + 10'sd1;
        end else begin
            n_in_pos.col = r_in_pos.col + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_pos <= '0;
        end else if (cfg_hit) begin
            r_in_pos <= '0;
        end else if (s_count) begin
            r_in_pos <= n_in_pos;
        end
    end

    // -------------------------------------------------------------- stages
    assign o_s_axis_tready = s1_ready;

    bmorph_stage #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_stage1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s1_ctl),
        .i_dims  (r_dims),
        .i_valid (s_count),
        .o_ready (s1_ready),
        .i_bit   (i_s_axis_tdata[0] && in_frame),
        .i_pos   (r_in_pos),
        .o_valid (s1_valid),
        .i_ready (s2_in_ready),
        .o_bit   (s1_bit),
        .o_pos   (s1_pos)
    );

    bmorph_stage #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_stage2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s2_ctl),
        .i_dims  (r_dims),
        .i_valid (s1_valid),
        .o_ready (s2_in_ready),
        .i_bit   (s1_bit),
        .i_pos   (s1_pos),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_bit   (s2_bit),
        .o_pos   (s2_pos)
    );

    // ------------------------------------------------------ output register
    assign s2_ready = !r_out_valid || i_m_axis_tready;
    // centers above the first row belong to no pixel: drop them
    assign emit     = !s2_pos.row[ROW_W-1];
    assign load_out = s2_valid && s2_ready && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_bit  <= s2_bit;
            r_out_row  <= s2_pos.row[7:0];
            r_out_col  <= s2_pos.col;
            r_out_last <= (s2_pos.row == h_last) && (s2_pos.col == w_last);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_col, r_out_row, r_out_bit};
    assign o_m_axis_tlast  = r_out_last;

    // ---------------------------------------------------------- assertions
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_in_pos == '0))
        else $error("register write did not restart the frame");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_pos.col < r_dims.width)
        else $error("input column beyond frame width");

    a_flush_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_axis_tuser && in_frame && !cfg_hit) |=> $stable(r_in_pos))
        else $error("flush inside the frame moved the position");

endmodule

FILE: tb/sv/tb_binary_morphology_3x3.sv
// Self-checking testbench for the 3x3 binary morphology block with a pixel-level scoreboard.
`timescale 1ns / 100ps

module tb_binary_morphology_3x3;
    import bmorph_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;  // index past the register list
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int LONG_HOLD     = 300;

    typedef struct {
        bit       value;
        bit [7:0] row;
        bit [7:0] col;
        bit       last;
    } t_morph_px;

    // Predicts each result pixel from the accepted pixel stream and checks it
    class morph_scoreboard;
        bit [1:0]    op;
        bit [7:0]    width_reg;
        bit [7:0]    height_reg;
        bit          img [0:254][0:255];
        int unsigned pos;
        t_morph_px   expected_px[$];
        int          errors;

        function new();
            op = MODE_ERODE;
            width_reg = 8'd255;
            height_reg = 8'd255;
            pos = 0;
            errors = 0;
        endfunction

        function void write_reg(bit [1:0] idx, bit [7:0] val);
            case (idx)
                REG_MODE:   op = val[1:0];
                REG_WIDTH:  width_reg = val;
                REG_HEIGHT: height_reg = val;
                default:    return;
            endcase
            pos = 0;
        endfunction

        // One 3x3 pass over the stored pixels: OR when growing, AND otherwise
        function bit window_bit(int r, int c, int w, int h, bit grow);
            bit acc;
            acc = !grow;
            for (int dr = -1; dr <= 1; dr++)
                for (int dc = -1; dc <= 1; dc++)
                    if (r + dr >= 0 && c + dc >= 0 && r + dr < h && c + dc < w)
                        acc = grow ? (acc | img[r + dr][c + dc])
                                   : (acc & img[r + dr][c + dc]);
            return acc;
        endfunction

        // Two cascaded passes; the second does the opposite of the first
        function bit cascade_bit(int r, int c, int w, int h, bit grow_first);
            bit acc;
            bit v;
            acc = grow_first;
            for (int dr = -1; dr <= 1; dr++)
                for (int dc = -1; dc <= 1; dc++)
                    if (r + dr >= 0 && c + dc >= 0 && r + dr < h && c + dc < w) begin
                        v = window_bit(r + dr, c + dc, w, h, grow_first);
                        acc = grow_first ? (acc & v) : (acc | v);
                    end
            return acc;
        endfunction

        function void take_pixel(bit pixel, bit flush);
            int unsigned w, h, total, lat, t, p;
            int r, c;
            t_morph_px px;
            w = (width_reg == 0) ? 1 : width_reg;
            h = (height_reg == 0) ? 1 : height_reg;
            total = w * h;
            lat = (op >= MODE_OPEN) ? 2 * (w + 1) : w + 1;
            t = pos;
            if (t < total) begin
                // a flush inside the frame is dropped without a trace
                if (flush)
                    return;
                img[t / w][t % w] = pixel;
            end
            if (t >= lat && t - lat < total) begin
                p = t - lat;
                r = p / w;
                c = p % w;
                case (op)
                    MODE_ERODE:  px.value = window_bit(r, c, w, h, 1'b0);
                    MODE_DILATE: px.value = window_bit(r, c, w, h, 1'b1);
                    MODE_OPEN:   px.value = cascade_bit(r, c, w, h, 1'b0);
                    default:     px.value = cascade_bit(r, c, w, h, 1'b1);
                endcase
                px.row = r[7:0];
                px.col = c[7:0];
                px.last = (p == total - 1);
                expected_px.push_back(px);
            end
            t++;
            if (t >= total + lat)
                t = 0;
            pos = t;
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got, t_morph_px px);
            $display("%0t: %s mismatch at row %0d col %0d: expected %0d, actual %0d",
                     $time, field, px.row, px.col, want, got);
            errors++;
        endfunction

        function void check_result(logic [23:0] data, logic last);
            t_morph_px px;
            if (expected_px.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d: expected none, actual %0b",
                         $time, data[8:1], data[16:9], data[0]);
                errors++;
                return;
            end
            px = expected_px.pop_front();
            if (data[0] !== px.value)
                report("result_bit", {7'd0, px.value}, {7'd0, data[0]}, px);
            if (data[8:1] !== px.row)
                report("result_row", px.row, data[8:1], px);
            if (data[16:9] !== px.col)
                report("result_col", px.col, data[16:9], px);
            if (last !== px.last)
                report("frame_end", {7'd0, px.last}, {7'd0, last}, px);
        endfunction

        function int pending();
            return expected_px.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_MODE;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'd0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    morph_scoreboard sb;
    int burst_left = 0;
    int work_items = 0;
    bit stress_armed = 1'b0;

    binary_morphology_3x3 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one pixel transfer; may idle between bursts, never drop valid between back-to-back items
    task automatic send_item(input bit pixel, input bit flush);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {7'd0, pixel};
        i_s_axis_tuser <= flush;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.take_pixel(pixel, flush);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Wait for the block to go quiet, then load a new setting
    task automatic set_phase(input logic [1:0] op, input logic [7:0] w, input logic [7:0] h);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        reg_write(REG_MODE, {6'($urandom_range(0, 63)), op});
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        if ($urandom_range(0, 3) == 0)
            reg_write(REG_SPARE, 8'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // 1x1 frame: stray flush, one pixel, drain led by a pixel, stray flush after
    task automatic tiny_frame(input logic [1:0] op, input logic [7:0] w, input logic [7:0] h,
                              input bit pixel);
        int lat;
        lat = (op >= MODE_OPEN) ? 4 : 2;
        set_phase(op, w, h);
        send_item(!pixel, 1'b1);
        send_item(pixel, 1'b0);
        send_item(1'b1, 1'b0);
        for (int d = 1; d < lat; d++)
            send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b1);
    endtask

    task automatic run_phase(input logic [1:0] op, input logic [7:0] w, input logic [7:0] h,
                             input int frames);
        int ew, eh, lat, density, cut;
        ew = (w == 0) ? 1 : w;
        eh = (h == 0) ? 1 : h;
        lat = (op >= MODE_OPEN) ? 2 * (ew + 1) : ew + 1;
        set_phase(op, w, h);
        for (int f = 0; f < frames; f++) begin
            density = $urandom_range(0, 100);
            for (int p = 0; p < ew * eh; p++) begin
                if ($urandom_range(0, 49) == 0)
                    send_item(1'($urandom_range(0, 1)), 1'b1);
                send_item($urandom_range(0, 99) < density, 1'b0);
                work_items++;
            end
            // now and then cut the drain short so the next frame finishes it
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lat) : 0;
            for (int d = 0; d < lat - cut; d++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(1'($urandom_range(0, 1)), 1'b0);
                else
                    send_item(1'($urandom_range(0, 1)), 1'b1);
                work_items++;
            end
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3)) send_item(1'($urandom_range(0, 1)), 1'b1);
        end
    endtask

    // Result side: check each transfer, stall on a changing pattern, hold off once for long
    initial begin : result_sink
        int style, style_left, hold_left, tick;
        bit hold_done, rdy;
        style = 0;
        style_left = 0;
        hold_left = 0;
        tick = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata, o_m_axis_tlast);
            tick++;
            if (!hold_done && stress_armed && i_s_axis_tvalid) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (style_left == 0) begin
                style = $urandom_range(0, 3);
                style_left = $urandom_range(50, 250);
            end
            style_left--;
            case (style)
                0:       rdy = 1'b1;
                1:       rdy = $urandom_range(0, 9) < 7;
                2:       rdy = $urandom_range(0, 3) == 0;
                default: rdy = (tick % 5) < 3;
            endcase
            if (hold_left > 0) begin
                rdy = 1'b0;
                hold_left--;
            end
            i_m_axis_tready <= rdy;
        end
    end

    initial begin : stimulus
        logic [7:0] w, h;
        int n;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every operation on a single-pixel frame, zero sizes standing for one
        tiny_frame(MODE_ERODE, 8'd0, 8'd0, 1'b1);
        tiny_frame(MODE_DILATE, 8'd1, 8'd0, 1'b0);
        tiny_frame(MODE_OPEN, 8'd0, 8'd1, 1'b1);
        tiny_frame(MODE_CLOSE, 8'd1, 8'd1, 1'b0);

        stress_armed = 1'b1;
        run_phase(2'($urandom_range(0, 3)), 8'd255, 8'd1, 1);
        run_phase(2'($urandom_range(0, 3)), 8'd1, 8'd255, 1);
        while (work_items < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 14) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
            h = ($urandom_range(0, 14) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
            run_phase(2'($urandom_range(0, 3)), w, h, $urandom_range(1, 3));
        end

        i_s_axis_tvalid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && sb.pending() != 0; n++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/bmorph_pkg.sv
hdl/bmorph_ram.sv
hdl/bmorph_stage.sv
hdl/binary_morphology_3x3.sv
tb/sv/tb_binary_morphology_3x3.sv
